// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, sampled on the rising clock edge, off during reset
`define BBC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed: lbl");

// implication from an antecedent in the same cycle
`define BBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: lbl");

// implication checked in the cycle after the antecedent
`define BBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: lbl");

`endif

// ----- hw/rtl/bbc_pkg.sv -----
// shared types and constants of the buffer cache tag directory
// used by every module of the block and by its checker
package bbc_pkg;

	localparam int ENTRIES_DEF = 32;
	localparam int SLOT_W = 5;
	localparam int DEV_W = 8;
	localparam int BLK_W = 32;
	localparam int REF_W = 8;
	localparam int TICK_W = 24;

	localparam logic [REF_W-1:0] REF_MAX = '1;
	localparam logic [REF_W-1:0] REF_ONE = REF_W'(1);

	typedef enum logic [1:0] {
		MODE_GET = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_PIN = 2'd2,
		MODE_UNPIN = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK = 2'd0,
		STAT_NOFREE = 2'd1,
		STAT_UNDER = 2'd2,
		STAT_OVER = 2'd3
	} status_t;

	typedef struct packed {
		mode_t mode;
		logic [DEV_W-1:0] device;
		logic [BLK_W-1:0] block_number;
		logic [SLOT_W-1:0] entry_index;
		logic [TICK_W-1:0] now_tick;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] buffer_slot;
		logic hit;
		logic needs_read;
		status_t status;
	} rsp_t;

	typedef struct packed {
		logic [DEV_W-1:0] dev;
		logic [BLK_W-1:0] blk;
		logic [REF_W-1:0] refs;
		logic [TICK_W-1:0] stamp;
		logic dvalid;
	} dir_entry_t;

	typedef struct packed {
		logic clear;
		logic sample;
	} scan_ctl_t;

	typedef struct packed {
		logic match_found;
		logic match_dvalid;
		logic match_full;
		logic free_found;
	} scan_flags_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_READ,
		ST_MODIFY,
		ST_FINISH
	} state_t;

endpackage

// ----- hw/rtl/bbc_dir_mem.sv -----
// directory memory: one entry per buffer, one write and one registered read a cycle
// depends on bbc_pkg; per-entry written bits make unwritten entries read as zero
module bbc_dir_mem import bbc_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF,
	localparam int IW = $clog2(ENTRIES)
) (
	input logic clk,
	input logic arst_n,
	input logic [IW-1:0] rd_addr,
	output dir_entry_t rd_data,
	input logic wr_en,
	input logic [IW-1:0] wr_addr,
	input dir_entry_t wr_data
);

	dir_entry_t mem [ENTRIES];
	dir_entry_t rd_data_s1;
	logic [ENTRIES-1:0] written_q;
	logic rd_written_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_written_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			rd_written_s1 <= written_q[rd_addr];
		end
	end

	assign rd_data = rd_written_s1 ? rd_data_s1 : '0;

endmodule

// ----- hw/rtl/bbc_scan.sv -----
// scan unit: tag compare and oldest-free search, one entry per cycle
// depends on bbc_pkg; keeps the lowest matching entry and the oldest free one
module bbc_scan import bbc_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF,
	localparam int IW = $clog2(ENTRIES)
) (
	input logic clk,
	input logic arst_n,
	input scan_ctl_t ctl,
	input logic [IW-1:0] idx,
	input dir_entry_t ent,
	input logic [DEV_W-1:0] device,
	input logic [BLK_W-1:0] block_number,
	output scan_flags_t flags,
	output logic [IW-1:0] match_idx,
	output logic [REF_W-1:0] match_refs,
	output logic [IW-1:0] free_idx
);

	logic match_found_q;
	logic free_found_q;
	logic [IW-1:0] match_idx_q;
	logic [REF_W-1:0] match_refs_q;
	logic match_dvalid_q;
	logic [IW-1:0] free_idx_q;
	logic [TICK_W-1:0] oldest_q;
	logic is_match;
	logic take_match;
	logic take_free;

	always_comb begin
		is_match = (ent.dev == device) && (ent.blk == block_number);
		take_match = ctl.sample && !match_found_q && is_match;
		take_free = ctl.sample && (ent.refs == '0) && (!free_found_q || (ent.stamp < oldest_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			free_found_q <= 1'b0;
		end else if (ctl.clear) begin
			match_found_q <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (take_match) begin
				match_found_q <= 1'b1;
			end
			if (take_free) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_match) begin
			match_idx_q <= idx;
			match_refs_q <= ent.refs;
			match_dvalid_q <= ent.dvalid;
		end
		if (take_free) begin
			free_idx_q <= idx;
			oldest_q <= ent.stamp;
		end
	end

	always_comb begin
		flags.match_found = match_found_q;
		flags.match_dvalid = match_dvalid_q;
		flags.match_full = (match_refs_q == REF_MAX);
		flags.free_found = free_found_q;
	end

	assign match_idx = match_idx_q;
	assign match_refs = match_refs_q;
	assign free_idx = free_idx_q;

endmodule

// ----- hw/rtl/block_buffer_cache_lru.sv -----
// Tag directory of a block buffer cache with least-recently-used replacement.
// One item is handled at a time; req_stall is high from acceptance until the
// result is loaded into the output register. A get walks the whole directory
// through the single read port of the directory memory, one entry per cycle,
// then passes through the drain and decide states to finish; release, pin and
// unpin pass through read, modify and finish, or go straight to finish when
// entry_index lies beyond the directory. No clearing pass follows reset: the
// block is ready as soon as arst_n is released. Ties between matching tags or
// equally old free entries go to the lowest index.
// depends on bbc_pkg, bbc_dir_mem and bbc_scan
module block_buffer_cache_lru import bbc_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp
);

	localparam int IW = $clog2(ENTRIES);

	state_t state_q, state_d;
	logic [IW-1:0] cnt_q, cnt_d;
	logic [IW-1:0] scan_idx_s1;
	req_t req_q;
	rsp_t res_q, res_d;
	logic res_load;
	rsp_t rsp_q;
	logic rsp_valid_q;
	logic req_accept;
	logic idx_in_range;

	logic [IW-1:0] rd_addr;
	dir_entry_t rd_data;
	logic wr_en;
	logic [IW-1:0] wr_addr;
	dir_entry_t wr_data;

	scan_ctl_t scan_ctl;
	scan_flags_t flags;
	logic [IW-1:0] match_idx;
	logic [REF_W-1:0] match_refs;
	logic [IW-1:0] free_idx;

	bbc_dir_mem #(.ENTRIES(ENTRIES)) u_dir (
		.clk(clk),
		.arst_n(arst_n),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	bbc_scan #(.ENTRIES(ENTRIES)) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(scan_ctl),
		.idx(scan_idx_s1),
		.ent(rd_data),
		.device(req_q.device),
		.block_number(req_q.block_number),
		.flags(flags),
		.match_idx(match_idx),
		.match_refs(match_refs),
		.free_idx(free_idx)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign idx_in_range = (32'(req.entry_index) < 32'(ENTRIES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (state_q == ST_FINISH && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= cnt_q;
		if (req_accept) begin
			req_q <= req;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (state_q == ST_FINISH && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q <= res_q;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		rd_addr = cnt_q;
		wr_en = 1'b0;
		wr_addr = cnt_q;
		wr_data = rd_data;
		scan_ctl = '0;
		res_load = 1'b0;
		res_d = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_accept) begin
					cnt_d = '0;
					if (req.mode == MODE_GET) begin
						scan_ctl.clear = 1'b1;
						state_d = ST_SCAN;
					end else if (idx_in_range) begin
						state_d = ST_READ;
					end else begin
						res_load = 1'b1;
						res_d.buffer_slot = req.entry_index;
						res_d.status = STAT_OK;
						state_d = ST_FINISH;
					end
				end
			end
			ST_SCAN: begin
				rd_addr = cnt_q;
				scan_ctl.sample = (cnt_q != '0);
				cnt_d = IW'(cnt_q + 1'b1);
				if (cnt_q == IW'(ENTRIES - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				scan_ctl.sample = 1'b1;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				res_load = 1'b1;
				state_d = ST_FINISH;
				wr_data.dev = req_q.device;
				wr_data.blk = req_q.block_number;
				wr_data.stamp = req_q.now_tick;
				wr_data.dvalid = 1'b1;
				priority if (flags.match_found) begin
					res_d.buffer_slot = SLOT_W'(match_idx);
					res_d.hit = 1'b1;
					if (flags.match_full) begin
						res_d.status = STAT_OVER;
					end else begin
						wr_en = 1'b1;
						wr_addr = match_idx;
						wr_data.refs = REF_W'(match_refs + REF_ONE);
						res_d.needs_read = !flags.match_dvalid;
						res_d.status = STAT_OK;
					end
				end else if (flags.free_found) begin
					wr_en = 1'b1;
					wr_addr = free_idx;
					wr_data.refs = REF_ONE;
					res_d.buffer_slot = SLOT_W'(free_idx);
					res_d.needs_read = 1'b1;
					res_d.status = STAT_OK;
				end else begin
					res_d.status = STAT_NOFREE;
				end
			end
			ST_READ: begin
				rd_addr = IW'(req_q.entry_index);
				state_d = ST_MODIFY;
			end
			ST_MODIFY: begin
				res_load = 1'b1;
				state_d = ST_FINISH;
				wr_addr = IW'(req_q.entry_index);
				res_d.buffer_slot = req_q.entry_index;
				res_d.status = STAT_OK;
				if (req_q.mode == MODE_PIN) begin
					if (rd_data.refs == REF_MAX) begin
						res_d.status = STAT_OVER;
					end else begin
						wr_en = 1'b1;
						wr_data.refs = REF_W'(rd_data.refs + REF_ONE);
					end
				end else begin
					if (rd_data.refs == '0) begin
						res_d.status = STAT_UNDER;
					end else begin
						wr_en = 1'b1;
						wr_data.refs = REF_W'(rd_data.refs - REF_ONE);
					end
				end
			end
			ST_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

// ----- hw/rtl/bbc_checker.sv -----
// port-level checker of the buffer cache tag directory, bound to the top level
// depends on bbc_pkg and assert_macros.svh
`include "assert_macros.svh"

module bbc_checker import bbc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	// a result waiting on the output does not change
	`BBC_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// one item at a time: an accepted item closes the input
	`BBC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && !req_stall, req_stall)

	// a missing free entry yields an empty result
	`BBC_ASSERT_IMPL(a_nofree_empty, clk, arst_n, rsp_valid && rsp.status == STAT_NOFREE, rsp.buffer_slot == '0 && !rsp.hit && !rsp.needs_read)

	// a hit never reports no free entry or underflow
	`BBC_ASSERT_IMPL(a_hit_status, clk, arst_n, rsp_valid && rsp.hit, rsp.status == STAT_OK || rsp.status == STAT_OVER)

	// an overflow leaves the entry untouched, so no read is asked for
	`BBC_ASSERT_IMPL(a_over_no_read, clk, arst_n, rsp_valid && rsp.status == STAT_OVER, !rsp.needs_read)

endmodule

bind block_buffer_cache_lru bbc_checker u_bbc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req(req),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp(rsp)
);
